/* src/mavdf_pkg.sv */
// ----------------------------------------------------------------------------
// MAVLink v1 receive deframer package
// Shared types, codes and helper functions for the deframer front end,
// request queue and result back end.
// ----------------------------------------------------------------------------
package mavdf_pkg;

    // Parser phase of the front end.
    typedef enum logic [3:0] {
        PH_START   = 4'd0,
        PH_LEN     = 4'd1,
        PH_SEQ     = 4'd2,
        PH_SYS     = 4'd3,
        PH_COMP    = 4'd4,
        PH_MSGID   = 4'd5,
        PH_PAYLOAD = 4'd6,
        PH_CRC_LO  = 4'd7,
        PH_CRC_HI  = 4'd8
    } t_phase;

    // Result kinds.
    localparam logic [1:0] KIND_CAN     = 2'd0;
    localparam logic [1:0] KIND_ACK     = 2'd1;
    localparam logic [1:0] KIND_VERSION = 2'd2;

    // Ack result codes.
    localparam logic ACK_ACCEPTED    = 1'b0;
    localparam logic ACK_UNSUPPORTED = 1'b1;

    // Framing constants.
    localparam logic [7:0]  START_BYTE = 8'hFE;
    localparam logic [15:0] CRC_SEED   = 16'hFFFF;

    // Message ids that the parser accepts.
    localparam logic [7:0] ID_HEARTBEAT   = 8'd0;
    localparam logic [7:0] ID_PARAM_READ  = 8'd20;
    localparam logic [7:0] ID_PARAM_LIST  = 8'd21;
    localparam logic [7:0] ID_MANUAL_CTRL = 8'd69;
    localparam logic [7:0] ID_CMD_LONG    = 8'd76;

    // Command numbers handled by the long command message.
    localparam logic [15:0] CMD_ARM_DISARM = 16'd400;
    localparam logic [15:0] CMD_VERSION    = 16'd520;
    localparam logic [15:0] CMD_CAPS       = 16'd521;
    localparam logic [15:0] CMD_REQ_MSG    = 16'd512;

    // CAN identifiers.
    localparam logic [10:0] CAN_ID_PITCH_ROLL = 11'h200;
    localparam logic [10:0] CAN_ID_THRUST_YAW = 11'h201;
    localparam logic [10:0] CAN_ID_ARM        = 11'h202;

    localparam logic [2:0] CAN_LEN_AXES = 3'd4;
    localparam logic [2:0] CAN_LEN_ARM  = 3'd1;

    // Bounds for "param1 > 0.5" on the raw IEEE single bits.
    localparam logic [31:0] ARM_LOW_BITS  = 32'h3F00_0000;
    localparam logic [31:0] ARM_HIGH_BITS = 32'h7F80_0000;

    // One request handed from the front end to the back end.
    typedef struct packed {
        logic        is_cmd;
        logic [31:0] word0;
        logic [31:0] word1;
        logic [15:0] command;
    } t_request;

    // X.25 CRC-16 update over one byte.
    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
        logic [7:0] t;
        t = b ^ crc[7:0];
        t = t ^ (t << 4);
        return {8'h00, crc[15:8]} ^ {t, 8'h00} ^ {5'b00000, t, 3'b000}
             ^ {12'h000, t[7:4]};
    endfunction

    // Per-message extra byte folded into the checksum.
    function automatic logic [7:0] extra_byte(input logic [7:0] id);
        logic [7:0] e;
        case (id)
            ID_HEARTBEAT:   e = 8'd50;
            ID_PARAM_READ:  e = 8'd214;
            ID_PARAM_LIST:  e = 8'd159;
            ID_CMD_LONG:    e = 8'd152;
            ID_MANUAL_CTRL: e = 8'd243;
            default:        e = 8'd0;
        endcase
        return e;
    endfunction

endpackage

/* src/mavdf_front.sv */
// ----------------------------------------------------------------------------
// MAVLink v1 deframer front end
// Parses received bytes, runs the checksum, keeps the payload bytes that the
// actions read and pushes one request per valid actionable frame.
// ----------------------------------------------------------------------------
module mavdf_front #(
    parameter int MAX_PAYLOAD = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic [7:0]           i_rx_byte,
    output logic                 o_push,
    output mavdf_pkg::t_request  o_request
);

    localparam int         LEN_W = $clog2(MAX_PAYLOAD + 1);
    localparam logic [7:0] MAX_B = 8'(MAX_PAYLOAD);

    mavdf_pkg::t_phase r_phase, n_phase;
    logic [LEN_W-1:0]  r_len, n_len;
    logic [LEN_W-1:0]  r_index, n_index;
    logic [7:0]        r_msg_id, n_msg_id;
    logic [15:0]       r_crc, n_crc;
    logic [7:0]        r_crc_lo, n_crc_lo;

    // Payload bytes that the actions read: bytes 0..7, 28 and 29.
    logic [7:0]        r_pl [8];
    logic [7:0]        r_pl28;
    logic [7:0]        r_pl29;

    logic [15:0]       crc_in;
    logic [LEN_W-1:0]  index_inc;
    logic              known_id;
    logic              crc_match;

    assign crc_in    = mavdf_pkg::crc_step(r_crc, i_rx_byte);
    assign index_inc = r_index + LEN_W'(1);
    assign known_id  = (i_rx_byte == mavdf_pkg::ID_HEARTBEAT)
                    || (i_rx_byte == mavdf_pkg::ID_PARAM_READ)
                    || (i_rx_byte == mavdf_pkg::ID_PARAM_LIST)
                    || (i_rx_byte == mavdf_pkg::ID_MANUAL_CTRL)
                    || (i_rx_byte == mavdf_pkg::ID_CMD_LONG);
    assign crc_match = mavdf_pkg::crc_step(r_crc, mavdf_pkg::extra_byte(r_msg_id))
                    == {i_rx_byte, r_crc_lo};

    // Next-state logic of the parser.
    always_comb begin
        n_phase  = r_phase;
        n_len    = r_len;
        n_index  = r_index;
        n_msg_id = r_msg_id;
        n_crc    = r_crc;
        n_crc_lo = r_crc_lo;
        if (i_accept) begin
            case (r_phase)
                mavdf_pkg::PH_LEN: begin
                    if (i_rx_byte > MAX_B) begin
                        n_phase = mavdf_pkg::PH_START;
                    end else begin
                        n_len   = i_rx_byte[LEN_W-1:0];
                        n_crc   = crc_in;
                        n_phase = mavdf_pkg::PH_SEQ;
                    end
                end
                mavdf_pkg::PH_SEQ: begin
                    n_crc   = crc_in;
                    n_phase = mavdf_pkg::PH_SYS;
                end
                mavdf_pkg::PH_SYS: begin
                    n_crc   = crc_in;
                    n_phase = mavdf_pkg::PH_COMP;
                end
                mavdf_pkg::PH_COMP: begin
                    n_crc   = crc_in;
                    n_phase = mavdf_pkg::PH_MSGID;
                end
                mavdf_pkg::PH_MSGID: begin
                    if (!known_id) begin
                        n_phase = mavdf_pkg::PH_START;
                    end else begin
                        n_msg_id = i_rx_byte;
                        n_index  = '0;
                        n_crc    = crc_in;
                        n_phase  = (r_len != '0) ? mavdf_pkg::PH_PAYLOAD
                                                 : mavdf_pkg::PH_CRC_LO;
                    end
                end
                mavdf_pkg::PH_PAYLOAD: begin
                    n_crc   = crc_in;
                    n_index = index_inc;
                    if (index_inc >= r_len) begin
                        n_phase = mavdf_pkg::PH_CRC_LO;
                    end
                end
                mavdf_pkg::PH_CRC_LO: begin
                    n_crc_lo = i_rx_byte;
                    n_phase  = mavdf_pkg::PH_CRC_HI;
                end
                mavdf_pkg::PH_CRC_HI: begin
                    n_phase = mavdf_pkg::PH_START;
                end
                default: begin
                    if (i_rx_byte == mavdf_pkg::START_BYTE) begin
                        n_crc   = mavdf_pkg::CRC_SEED;
                        n_phase = mavdf_pkg::PH_LEN;
                    end else begin
                        n_phase = mavdf_pkg::PH_START;
                    end
                end
            endcase
        end
    end

    // Request output: a checked manual control or long command frame.
    always_comb begin
        o_push = i_accept && (r_phase == mavdf_pkg::PH_CRC_HI) && crc_match
              && ((r_msg_id == mavdf_pkg::ID_MANUAL_CTRL)
               || (r_msg_id == mavdf_pkg::ID_CMD_LONG));
        o_request.is_cmd  = (r_msg_id == mavdf_pkg::ID_CMD_LONG);
        o_request.word0   = {r_pl[3], r_pl[2], r_pl[1], r_pl[0]};
        o_request.word1   = {r_pl[7], r_pl[6], r_pl[5], r_pl[4]};
        o_request.command = {r_pl29, r_pl28};
    end

    // Parser registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= mavdf_pkg::PH_START;
            r_len    <= '0;
            r_index  <= '0;
            r_msg_id <= '0;
            r_crc    <= mavdf_pkg::CRC_SEED;
            r_crc_lo <= '0;
        end else begin
            r_phase  <= n_phase;
            r_len    <= n_len;
            r_index  <= n_index;
            r_msg_id <= n_msg_id;
            r_crc    <= n_crc;
            r_crc_lo <= n_crc_lo;
        end
    end

    // Payload capture; bytes outside the kept positions are not needed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 8; k++) begin
                r_pl[k] <= '0;
            end
            r_pl28 <= '0;
            r_pl29 <= '0;
        end else if (i_accept && (r_phase == mavdf_pkg::PH_PAYLOAD)) begin
            if (r_index < LEN_W'(8)) begin
                r_pl[r_index[2:0]] <= i_rx_byte;
            end
            if (r_index == LEN_W'(28)) begin
                r_pl28 <= i_rx_byte;
            end
            if (r_index == LEN_W'(29)) begin
                r_pl29 <= i_rx_byte;
            end
        end
    end

endmodule

/* src/mavdf_queue.sv */
// ----------------------------------------------------------------------------
// MAVLink v1 deframer request queue
// Two-entry queue that decouples the byte parser from the result back end.
// ----------------------------------------------------------------------------
module mavdf_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  mavdf_pkg::t_request  i_request,
    input  logic                 i_pop,
    output logic                 o_full,
    output logic                 o_empty,
    output mavdf_pkg::t_request  o_head
);

    mavdf_pkg::t_request r_mem [2];
    logic                r_wr, n_wr;
    logic                r_rd, n_rd;
    logic [1:0]          r_cnt, n_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_head  = r_mem[r_rd];

    // Pointer and count update.
    always_comb begin
        n_wr  = i_push ? ~r_wr : r_wr;
        n_rd  = i_pop  ? ~r_rd : r_rd;
        n_cnt = r_cnt + {1'b0, i_push} - {1'b0, i_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_request;
        end
    end

endmodule

/* src/mavdf_back.sv */
// ----------------------------------------------------------------------------
// MAVLink v1 deframer back end
// Expands each queued request into one or two results and holds them in an
// output register until the downstream side takes them.
// ----------------------------------------------------------------------------
module mavdf_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_empty,
    input  mavdf_pkg::t_request  i_head,
    output logic                 o_pop,
    input  logic                 i_stall,
    output logic                 o_valid,
    output logic [1:0]           o_kind,
    output logic [10:0]          o_can_id,
    output logic [2:0]           o_can_length,
    output logic [31:0]          o_can_data,
    output logic [15:0]          o_ack_command,
    output logic                 o_ack_code,
    output logic                 o_last
);

    logic        r_valid, n_valid;
    logic        r_sub, n_sub;
    logic [1:0]  r_kind, n_kind;
    logic [10:0] r_can_id, n_can_id;
    logic [2:0]  r_can_length, n_can_length;
    logic [31:0] r_can_data, n_can_data;
    logic [15:0] r_ack_command, n_ack_command;
    logic        r_ack_code, n_ack_code;
    logic        r_last, n_last;

    logic        load;
    logic        arm;
    logic        is_arm_cmd;
    logic        is_ver_cmd;
    logic        is_ok_cmd;

    assign load = !i_empty && (!r_valid || !i_stall);
    assign arm  = (i_head.word0 > mavdf_pkg::ARM_LOW_BITS)
               && (i_head.word0 <= mavdf_pkg::ARM_HIGH_BITS);
    assign is_arm_cmd = (i_head.command == mavdf_pkg::CMD_ARM_DISARM);
    assign is_ver_cmd = (i_head.command == mavdf_pkg::CMD_VERSION);
    assign is_ok_cmd  = (i_head.command == mavdf_pkg::CMD_CAPS)
                     || (i_head.command == mavdf_pkg::CMD_REQ_MSG);

    // Decode the current result of the head request.
    always_comb begin
        n_kind        = mavdf_pkg::KIND_CAN;
        n_can_id      = '0;
        n_can_length  = '0;
        n_can_data    = '0;
        n_ack_command = '0;
        n_ack_code    = mavdf_pkg::ACK_ACCEPTED;
        n_last        = 1'b1;
        if (!i_head.is_cmd) begin
            n_can_length = mavdf_pkg::CAN_LEN_AXES;
            if (!r_sub) begin
                n_can_id   = mavdf_pkg::CAN_ID_PITCH_ROLL;
                n_can_data = i_head.word0;
                n_last     = 1'b0;
            end else begin
                n_can_id   = mavdf_pkg::CAN_ID_THRUST_YAW;
                n_can_data = i_head.word1;
            end
        end else if (is_arm_cmd && !r_sub) begin
            n_can_id     = mavdf_pkg::CAN_ID_ARM;
            n_can_length = mavdf_pkg::CAN_LEN_ARM;
            n_can_data   = {31'd0, arm};
            n_last       = 1'b0;
        end else if (is_ver_cmd && r_sub) begin
            n_kind = mavdf_pkg::KIND_VERSION;
        end else begin
            n_kind        = mavdf_pkg::KIND_ACK;
            n_ack_command = i_head.command;
            n_ack_code    = (is_arm_cmd || is_ver_cmd || is_ok_cmd)
                          ? mavdf_pkg::ACK_ACCEPTED : mavdf_pkg::ACK_UNSUPPORTED;
            n_last        = !is_ver_cmd;
        end
    end

    // Output valid, sub-result index and queue pop.
    always_comb begin
        o_pop   = load && n_last;
        n_valid = load ? 1'b1 : (r_valid && i_stall);
        n_sub   = load ? !n_last : r_sub;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sub   <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_sub   <= n_sub;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_kind        <= n_kind;
            r_can_id      <= n_can_id;
            r_can_length  <= n_can_length;
            r_can_data    <= n_can_data;
            r_ack_command <= n_ack_command;
            r_ack_code    <= n_ack_code;
            r_last        <= n_last;
        end
    end

    assign o_valid       = r_valid;
    assign o_kind        = r_kind;
    assign o_can_id      = r_can_id;
    assign o_can_length  = r_can_length;
    assign o_can_data    = r_can_data;
    assign o_ack_command = r_ack_command;
    assign o_ack_code    = r_ack_code;
    assign o_last        = r_last;

endmodule

/* src/mavlink_v1_receive_deframer.sv */
// ----------------------------------------------------------------------------
// MAVLink v1 receive deframer
// Parses received radio bytes into MAVLink v1 frames, checks the X.25
// checksum and turns manual control and long command frames into CAN, ack
// and version requests.
//
//   Channel | Direction | Handshake           | Payload
//   --------+-----------+---------------------+---------------------------------
//   rx      | in        | i_valid / o_stall   | i_rx_byte
//   result  | out       | o_valid / i_stall   | o_kind, o_can_id, o_can_length,
//           |           |                     | o_can_data, o_ack_command,
//           |           |                     | o_ack_code, o_last
//
// One byte is taken per cycle while o_stall is low, and the checksum and
// phase are registered. A valid manual control or long command frame queues
// one request; the back end expands it into one or two results.
// A two-entry request queue sits between parser and output register;
// o_stall rises only while that queue is full.
// Synchronous active-low reset; the parser starts out hunting for 0xFE.
// ----------------------------------------------------------------------------
module mavlink_v1_receive_deframer #(
    parameter int MAX_PAYLOAD = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_kind,
    output logic [10:0] o_can_id,
    output logic [2:0]  o_can_length,
    output logic [31:0] o_can_data,
    output logic [15:0] o_ack_command,
    output logic        o_ack_code,
    output logic        o_last
);

    logic                accept;
    logic                push;
    logic                pop;
    logic                full;
    logic                empty;
    mavdf_pkg::t_request request;
    mavdf_pkg::t_request head;

    assign o_stall = full;
    assign accept  = i_valid && !full;

    // Byte parser.
    mavdf_front #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_rx_byte (i_rx_byte),
        .o_push    (push),
        .o_request (request)
    );

    // Request queue.
    mavdf_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_request (request),
        .i_pop     (pop),
        .o_full    (full),
        .o_empty   (empty),
        .o_head    (head)
    );

    // Result expansion and output register.
    mavdf_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (empty),
        .i_head        (head),
        .o_pop         (pop),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_kind        (o_kind),
        .o_can_id      (o_can_id),
        .o_can_length  (o_can_length),
        .o_can_data    (o_can_data),
        .o_ack_command (o_ack_command),
        .o_ack_code    (o_ack_code),
        .o_last        (o_last)
    );

endmodule

/* dv/testbench.sv */
// ----------------------------------------------------------------------------
// MAVLink v1 receive deframer testbench
// Sends radio bytes to the deframer and checks every result it returns. The
// bytes form valid frames, frames with bad lengths, unknown ids, bad checksums
// or missing bytes, and line noise. A scoreboard runs its own copy of the
// parser and checksum and predicts each result. A directed set of frames
// covers the edge cases, and a random mix follows. Both handshakes idle at
// random, and the result side holds off once for a long stretch.
// ----------------------------------------------------------------------------
localparam int PAYLOAD_MAX = 64;

// One result as it appears on the output ports, in port order.
typedef struct packed {
    logic [1:0]  kind;
    logic [10:0] can_id;
    logic [2:0]  can_length;
    logic [31:0] can_data;
    logic [15:0] ack_command;
    logic        ack_code;
    logic        last;
} t_result;

// Defects that the frame builder can put into a frame.
typedef enum {FRAME_CLEAN, FRAME_BAD_CRC, FRAME_CUT} t_flaw;

// Bit-serial X.25 checksum: reflected polynomial 0x8408.
function automatic logic [15:0] x25_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] acc;
    acc = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++)
        acc = acc[0] ? ((acc >> 1) ^ 16'h8408) : (acc >> 1);
    return acc;
endfunction

// Extra byte that each accepted message folds into its checksum.
function automatic logic [7:0] msg_extra(input logic [7:0] id);
    case (id)
        mavdf_pkg::ID_HEARTBEAT:   return 8'd50;
        mavdf_pkg::ID_PARAM_READ:  return 8'd214;
        mavdf_pkg::ID_PARAM_LIST:  return 8'd159;
        mavdf_pkg::ID_CMD_LONG:    return 8'd152;
        mavdf_pkg::ID_MANUAL_CTRL: return 8'd243;
        default:                   return 8'd0;
    endcase
endfunction

function automatic logic id_accepted(input logic [7:0] id);
    return id inside {mavdf_pkg::ID_HEARTBEAT, mavdf_pkg::ID_PARAM_READ,
                      mavdf_pkg::ID_PARAM_LIST, mavdf_pkg::ID_MANUAL_CTRL,
                      mavdf_pkg::ID_CMD_LONG};
endfunction

// Tracks the parser state and the results that the deframer still owes.
class deframer_scoreboard;
    mavdf_pkg::t_phase phase;
    logic [6:0]  frame_len;
    logic [7:0]  msg_id;
    logic [6:0]  pay_idx;
    logic [7:0]  pay_store [PAYLOAD_MAX];
    logic [15:0] crc_acc;
    logic [7:0]  crc_low;
    t_result     due_results [$];
    int          byte_count;
    int          good_frames;
    int          predicted_count;
    int          checked_count;
    int          mismatch_count;

    function new();
        phase = mavdf_pkg::PH_START;
        frame_len = '0;
        msg_id = '0;
        pay_idx = '0;
        crc_acc = mavdf_pkg::CRC_SEED;
        crc_low = '0;
        foreach (pay_store[k])
            pay_store[k] = 8'h00;
        byte_count = 0;
        good_frames = 0;
        predicted_count = 0;
        checked_count = 0;
        mismatch_count = 0;
    endfunction

    function logic [31:0] word_at(input int i);
        return {pay_store[i + 3], pay_store[i + 2], pay_store[i + 1], pay_store[i]};
    endfunction

    function void push_result(input logic [1:0] kind, input logic [10:0] can_id,
                              input logic [2:0] can_len, input logic [31:0] data,
                              input logic [15:0] cmd, input logic code, input logic last);
        t_result r;
        r.kind = kind;
        r.can_id = can_id;
        r.can_length = can_len;
        r.can_data = data;
        r.ack_command = cmd;
        r.ack_code = code;
        r.last = last;
        due_results.push_back(r);
        predicted_count++;
    endfunction

    // Results of a frame whose checksum matched. Short payloads read stale bytes.
    function void decode_frame();
        logic [15:0] cmd;
        logic        armed;
        cmd = {pay_store[29], pay_store[28]};
        armed = (word_at(0) > mavdf_pkg::ARM_LOW_BITS)
             && (word_at(0) <= mavdf_pkg::ARM_HIGH_BITS);
        if (msg_id == mavdf_pkg::ID_MANUAL_CTRL) begin
            push_result(mavdf_pkg::KIND_CAN, mavdf_pkg::CAN_ID_PITCH_ROLL,
                        mavdf_pkg::CAN_LEN_AXES, word_at(0), 16'h0, 1'b0, 1'b0);
            push_result(mavdf_pkg::KIND_CAN, mavdf_pkg::CAN_ID_THRUST_YAW,
                        mavdf_pkg::CAN_LEN_AXES, word_at(4), 16'h0, 1'b0, 1'b1);
        end else if (msg_id == mavdf_pkg::ID_CMD_LONG) begin
            case (cmd)
                mavdf_pkg::CMD_ARM_DISARM: begin
                    push_result(mavdf_pkg::KIND_CAN, mavdf_pkg::CAN_ID_ARM,
                                mavdf_pkg::CAN_LEN_ARM, {31'h0, armed},
                                16'h0, 1'b0, 1'b0);
                    push_result(mavdf_pkg::KIND_ACK, 11'h0, 3'h0, 32'h0, cmd,
                                mavdf_pkg::ACK_ACCEPTED, 1'b1);
                end
                mavdf_pkg::CMD_VERSION: begin
                    push_result(mavdf_pkg::KIND_ACK, 11'h0, 3'h0, 32'h0, cmd,
                                mavdf_pkg::ACK_ACCEPTED, 1'b0);
                    push_result(mavdf_pkg::KIND_VERSION, 11'h0, 3'h0, 32'h0, 16'h0,
                                1'b0, 1'b1);
                end
                mavdf_pkg::CMD_CAPS, mavdf_pkg::CMD_REQ_MSG: begin
                    push_result(mavdf_pkg::KIND_ACK, 11'h0, 3'h0, 32'h0, cmd,
                                mavdf_pkg::ACK_ACCEPTED, 1'b1);
                end
                default: begin
                    push_result(mavdf_pkg::KIND_ACK, 11'h0, 3'h0, 32'h0, cmd,
                                mavdf_pkg::ACK_UNSUPPORTED, 1'b1);
                end
            endcase
        end
    endfunction

    // Advance the parser by one accepted byte.
    function void note_byte(input logic [7:0] c);
        byte_count++;
        case (phase)
            mavdf_pkg::PH_LEN: begin
                if (c > PAYLOAD_MAX) begin
                    phase = mavdf_pkg::PH_START;
                end else begin
                    frame_len = c[6:0];
                    crc_acc = x25_update(crc_acc, c);
                    phase = mavdf_pkg::PH_SEQ;
                end
            end
            mavdf_pkg::PH_SEQ: begin
                crc_acc = x25_update(crc_acc, c);
                phase = mavdf_pkg::PH_SYS;
            end
            mavdf_pkg::PH_SYS: begin
                crc_acc = x25_update(crc_acc, c);
                phase = mavdf_pkg::PH_COMP;
            end
            mavdf_pkg::PH_COMP: begin
                crc_acc = x25_update(crc_acc, c);
                phase = mavdf_pkg::PH_MSGID;
            end
            mavdf_pkg::PH_MSGID: begin
                if (!id_accepted(c)) begin
                    phase = mavdf_pkg::PH_START;
                end else begin
                    msg_id = c;
                    pay_idx = '0;
                    crc_acc = x25_update(crc_acc, c);
                    phase = (frame_len != 0) ? mavdf_pkg::PH_PAYLOAD : mavdf_pkg::PH_CRC_LO;
                end
            end
            mavdf_pkg::PH_PAYLOAD: begin
                pay_store[pay_idx] = c;
                crc_acc = x25_update(crc_acc, c);
                pay_idx = pay_idx + 7'd1;
                if (pay_idx >= frame_len)
                    phase = mavdf_pkg::PH_CRC_LO;
            end
            mavdf_pkg::PH_CRC_LO: begin
                crc_low = c;
                phase = mavdf_pkg::PH_CRC_HI;
            end
            mavdf_pkg::PH_CRC_HI: begin
                if (x25_update(crc_acc, msg_extra(msg_id)) == {c, crc_low}) begin
                    good_frames++;
                    decode_frame();
                end
                phase = mavdf_pkg::PH_START;
            end
            default: begin
                if (c == mavdf_pkg::START_BYTE) begin
                    crc_acc = mavdf_pkg::CRC_SEED;
                    phase = mavdf_pkg::PH_LEN;
                end else begin
                    phase = mavdf_pkg::PH_START;
                end
            end
        endcase
    endfunction

    function void compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_count++;
        end
    endfunction

    // Compare one returned result with the oldest outstanding prediction.
    function void check_result(input t_result got);
        t_result want;
        if (due_results.size() == 0) begin
            $error("unpredicted result: kind %0d can_id 0x%0h ack_command %0d",
                   got.kind, got.can_id, got.ack_command);
            mismatch_count++;
            return;
        end
        want = due_results.pop_front();
        checked_count++;
        compare_field("kind", 32'(want.kind), 32'(got.kind));
        compare_field("can_id", 32'(want.can_id), 32'(got.can_id));
        compare_field("can_length", 32'(want.can_length), 32'(got.can_length));
        compare_field("can_data", want.can_data, got.can_data);
        compare_field("ack_command", 32'(want.ack_command), 32'(got.ack_command));
        compare_field("ack_code", 32'(want.ack_code), 32'(got.ack_code));
        compare_field("last", 32'(want.last), 32'(got.last));
    endfunction
endclass

module testbench;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 200;
    localparam int TAIL_CYCLES  = 20;
    localparam int ITEM_GOAL    = 850;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [7:0]  i_rx_byte = 8'h00;
    logic        i_stall = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [1:0]  o_kind;
    logic [10:0] o_can_id;
    logic [2:0]  o_can_length;
    logic [31:0] o_can_data;
    logic [15:0] o_ack_command;
    logic        o_ack_code;
    logic        o_last;

    deframer_scoreboard frames;
    logic [7:0] frame_body [PAYLOAD_MAX];
    int         burst_left = 0;
    logic       steady_send = 1'b0;
    int         hold_requests = 0;
    int         holds_served = 0;
    int         hold_left = 0;
    int         stall_pct = 0;
    int         mode_left = 0;
    int         cycle_count = 0;

    mavlink_v1_receive_deframer DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_rx_byte     (i_rx_byte),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_kind        (o_kind),
        .o_can_id      (o_can_id),
        .o_can_length  (o_can_length),
        .o_can_data    (o_can_data),
        .o_ack_command (o_ack_command),
        .o_ack_code    (o_ack_code),
        .o_last        (o_last)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Result side: check each accepted result and decide the next stall.
    // Stall density changes in random spans; a hold-off request forces a long stall.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall)
                frames.check_result({o_kind, o_can_id, o_can_length, o_can_data,
                                     o_ack_command, o_ack_code, o_last});
            if (mode_left == 0) begin
                case ($urandom_range(3))
                    0:       stall_pct <= 0;
                    1:       stall_pct <= 20;
                    2:       stall_pct <= 50;
                    default: stall_pct <= 85;
                endcase
                mode_left <= $urandom_range(30, 250);
            end else begin
                mode_left <= mode_left - 1;
            end
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                i_stall <= 1'b1;
            end else if (holds_served != hold_requests) begin
                holds_served <= hold_requests;
                hold_left <= HOLD_CYCLES;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    // Give up if the run never completes.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $error("run did not complete within %0d cycles", CYCLE_LIMIT);
            $display("Mismatches found");
            $finish;
        end
    end

    // Offer one byte and wait until it is taken. Bursts are separated by random gaps.
    task automatic send_byte(input logic [7:0] value);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = (steady_send || $urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid   <= 1'b1;
        i_rx_byte <= value;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        frames.note_byte(value);
    endtask

    // Build a frame around frame_body, with an optional defect, and send it.
    task automatic send_frame(input logic [7:0] len_field, input logic [7:0] id,
                              input t_flaw flaw);
        logic [15:0] crc;
        int          body_len;
        int          cut;
        logic [7:0]  bytes_out [$];
        body_len = (len_field > PAYLOAD_MAX) ? 0 : int'(len_field);
        bytes_out.push_back(mavdf_pkg::START_BYTE);
        bytes_out.push_back(len_field);
        repeat (3) bytes_out.push_back(8'($urandom_range(255)));
        bytes_out.push_back(id);
        for (int k = 0; k < body_len; k++)
            bytes_out.push_back(frame_body[k]);
        crc = mavdf_pkg::CRC_SEED;
        for (int k = 1; k < bytes_out.size(); k++)
            crc = x25_update(crc, bytes_out[k]);
        crc = x25_update(crc, msg_extra(id));
        if (flaw == FRAME_BAD_CRC)
            crc = crc ^ (16'h0001 << $urandom_range(15));
        bytes_out.push_back(crc[7:0]);
        bytes_out.push_back(crc[15:8]);
        if (flaw == FRAME_CUT) begin
            cut = $urandom_range(1, bytes_out.size() - 1);
            while (bytes_out.size() > cut)
                void'(bytes_out.pop_back());
        end
        foreach (bytes_out[k])
            send_byte(bytes_out[k]);
    endtask

    function automatic void fill_body(input logic [7:0] first, input logic [7:0] step);
        for (int k = 0; k < PAYLOAD_MAX; k++)
            frame_body[k] = 8'(first + step * k);
    endfunction

    function automatic void set_command(input logic [15:0] cmd);
        frame_body[28] = cmd[7:0];
        frame_body[29] = cmd[15:8];
    endfunction

    function automatic void set_param1(input logic [31:0] bits);
        {frame_body[3], frame_body[2], frame_body[1], frame_body[0]} = bits;
    endfunction

    // Raw param1 values around the arm threshold: 0.5, just above, +inf, NaN, -1, 1.
    function automatic logic [31:0] arm_edge(input int k);
        case (k)
            0:       return mavdf_pkg::ARM_LOW_BITS;
            1:       return mavdf_pkg::ARM_LOW_BITS + 32'd1;
            2:       return mavdf_pkg::ARM_HIGH_BITS;
            3:       return mavdf_pkg::ARM_HIGH_BITS + 32'd1;
            4:       return 32'hBF80_0000;
            default: return 32'h3F80_0000;
        endcase
    endfunction

    function automatic logic [31:0] pick_param1();
        if ($urandom_range(2) == 0)
            return $urandom;
        return arm_edge($urandom_range(5));
    endfunction

    function automatic logic [15:0] pick_command();
        case ($urandom_range(5))
            0:       return mavdf_pkg::CMD_ARM_DISARM;
            1:       return mavdf_pkg::CMD_VERSION;
            2:       return mavdf_pkg::CMD_CAPS;
            3:       return mavdf_pkg::CMD_REQ_MSG;
            default: return 16'($urandom);
        endcase
    endfunction

    // Mostly well-formed control frames with random content, plus broken ones and noise.
    task automatic send_random_frame();
        int         pick;
        logic [7:0] len;
        logic [7:0] id;
        t_flaw      flaw;
        pick = $urandom_range(99);
        for (int k = 0; k < PAYLOAD_MAX; k++)
            frame_body[k] = 8'($urandom_range(255));
        case ($urandom_range(19))
            0:       flaw = FRAME_BAD_CRC;
            1:       flaw = FRAME_CUT;
            default: flaw = FRAME_CLEAN;
        endcase
        if (pick < 40) begin
            id = mavdf_pkg::ID_MANUAL_CTRL;
            len = ($urandom_range(3) == 0) ? 8'($urandom_range(PAYLOAD_MAX))
                                           : 8'($urandom_range(8, 11));
        end else if (pick < 75) begin
            id = mavdf_pkg::ID_CMD_LONG;
            len = ($urandom_range(3) == 0) ? 8'($urandom_range(PAYLOAD_MAX))
                                           : 8'($urandom_range(30, 33));
            set_param1(pick_param1());
            set_command(pick_command());
        end else if (pick < 83) begin
            case ($urandom_range(2))
                0:       id = mavdf_pkg::ID_HEARTBEAT;
                1:       id = mavdf_pkg::ID_PARAM_READ;
                default: id = mavdf_pkg::ID_PARAM_LIST;
            endcase
            len = 8'($urandom_range(20));
        end else if (pick < 88) begin
            id = mavdf_pkg::ID_MANUAL_CTRL;
            len = 8'($urandom_range(PAYLOAD_MAX + 1, 255));
        end else if (pick < 93) begin
            do
                id = 8'($urandom_range(255));
            while (id_accepted(id));
            len = 8'($urandom_range(20));
        end else begin
            // Line noise between frames.
            repeat ($urandom_range(1, 6))
                send_byte(8'($urandom_range(255)));
            return;
        end
        send_frame(len, id, flaw);
    endtask

    // Stop offering bytes until every predicted result has been returned.
    task automatic wait_for_results();
        i_valid <= 1'b0;
        burst_left = 0;
        while (frames.due_results.size() != 0)
            @(posedge i_clk);
    endtask

    // Hold the result side off while short valid frames keep arriving,
    // so that the request queue fills and the input stalls.
    task automatic hold_off_run();
        hold_requests <= hold_requests + 1;
        steady_send = 1'b1;
        for (int k = 0; k < 8; k++)
            send_frame(8'd0, (k % 2 == 0) ? mavdf_pkg::ID_MANUAL_CTRL : mavdf_pkg::ID_CMD_LONG,
                       FRAME_CLEAN);
        steady_send = 1'b0;
    endtask

    initial begin
        frames = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty payloads right after reset read the cleared store.
        send_frame(8'd0, mavdf_pkg::ID_MANUAL_CTRL, FRAME_CLEAN);
        send_frame(8'd0, mavdf_pkg::ID_CMD_LONG, FRAME_CLEAN);
        fill_body(8'hFF, 8'h00);
        send_frame(8'd8, mavdf_pkg::ID_MANUAL_CTRL, FRAME_CLEAN);
        fill_body(8'h00, 8'h00);
        send_frame(8'd11, mavdf_pkg::ID_MANUAL_CTRL, FRAME_CLEAN);
        fill_body(8'h01, 8'h01);
        send_frame(8'(PAYLOAD_MAX), mavdf_pkg::ID_MANUAL_CTRL, FRAME_CLEAN);

        // Arm command around the 0.5 threshold, then the other commands.
        set_command(mavdf_pkg::CMD_ARM_DISARM);
        for (int k = 0; k < 6; k++) begin
            set_param1(arm_edge(k));
            send_frame(8'd33, mavdf_pkg::ID_CMD_LONG, FRAME_CLEAN);
        end
        set_command(mavdf_pkg::CMD_VERSION);
        send_frame(8'd33, mavdf_pkg::ID_CMD_LONG, FRAME_CLEAN);
        set_command(mavdf_pkg::CMD_CAPS);
        send_frame(8'd33, mavdf_pkg::ID_CMD_LONG, FRAME_CLEAN);
        set_command(mavdf_pkg::CMD_REQ_MSG);
        send_frame(8'd33, mavdf_pkg::ID_CMD_LONG, FRAME_CLEAN);
        set_command(16'hFFFF);
        send_frame(8'd33, mavdf_pkg::ID_CMD_LONG, FRAME_CLEAN);
        // A short command frame picks up the command left in the store.
        set_command(mavdf_pkg::CMD_VERSION);
        send_frame(8'd4, mavdf_pkg::ID_CMD_LONG, FRAME_CLEAN);

        // Accepted messages that produce nothing.
        send_frame(8'd9, mavdf_pkg::ID_HEARTBEAT, FRAME_CLEAN);
        send_frame(8'd20, mavdf_pkg::ID_PARAM_READ, FRAME_CLEAN);
        send_frame(8'd0, mavdf_pkg::ID_PARAM_LIST, FRAME_CLEAN);

        // Oversized lengths, a start byte in the length slot, unknown ids.
        send_frame(8'(PAYLOAD_MAX + 1), mavdf_pkg::ID_MANUAL_CTRL, FRAME_CLEAN);
        send_frame(8'hFF, mavdf_pkg::ID_MANUAL_CTRL, FRAME_CLEAN);
        send_byte(mavdf_pkg::START_BYTE);
        send_frame(8'd8, mavdf_pkg::ID_MANUAL_CTRL, FRAME_CLEAN);
        send_frame(8'd8, 8'd1, FRAME_CLEAN);
        send_frame(8'd8, 8'hFF, FRAME_CLEAN);

        // Checksum failure, and a frame cut short followed by a good one.
        send_frame(8'd8, mavdf_pkg::ID_MANUAL_CTRL, FRAME_BAD_CRC);
        send_frame(8'd33, mavdf_pkg::ID_CMD_LONG, FRAME_CUT);
        send_frame(8'd8, mavdf_pkg::ID_MANUAL_CTRL, FRAME_CLEAN);
        wait_for_results();

        // One long hold-off and a full drain, then a random mix up to the byte budget.
        hold_off_run();
        wait_for_results();
        while (frames.byte_count < ITEM_GOAL)
            send_random_frame();
        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d bytes; %0d frames passed the checksum; %0d results checked.",
                 frames.byte_count, frames.good_frames, frames.checked_count);
        $display("Covered all commands, arm edges, stale payloads, bad framing and hold-off.");
        if (frames.mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

/* sim.f */
src/mavdf_pkg.sv
src/mavdf_front.sv
src/mavdf_queue.sv
src/mavdf_back.sv
src/mavlink_v1_receive_deframer.sv
dv/testbench.sv
